@@ sv/lz77_pkg.sv @@
// Shared types and constants of the LZ77 greedy encoder.
`default_nettype none

package lz77_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCH = 2'd1;

    localparam int CFG_DATA_W = 11;

    localparam logic [10:0] WINDOW_RST    = 11'd1024;
    localparam logic [4:0]  MAX_MATCH_RST = 5'd16;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [10:0] match_offset;
        logic [4:0]  match_length;
        logic [7:0]  literal_value;
        logic        final_token;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_EMIT,
        S_COMMIT
    } t_state;

endpackage

`default_nettype wire

@@ sv/lz77_hist_mem.sv @@
// History ring memory: one write port, one read port with registered data.
`default_nettype none

module lz77_hist_mem #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(HISTORY_DEPTH)-1:0] i_waddr,
    input  wire logic [7:0]                       i_wdata,
    input  wire logic [$clog2(HISTORY_DEPTH)-1:0] i_raddr,
    output logic      [7:0]                       o_rdata
);

    logic [7:0] r_mem [HISTORY_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/lz77_match_unit.sv @@
// Shared compare unit: length of the common prefix of two byte rows, capped.
`default_nettype none

module lz77_match_unit #(
    parameter int LOOKAHEAD_DEPTH = 16
) (
    input  wire logic [LOOKAHEAD_DEPTH-1:0][7:0]         i_win,
    input  wire logic [LOOKAHEAD_DEPTH-1:0][7:0]         i_ref,
    input  wire logic [$clog2(LOOKAHEAD_DEPTH+1)-1:0]    i_lim,
    output logic      [$clog2(LOOKAHEAD_DEPTH+1)-1:0]    o_len
);

    localparam int LEN_W = $clog2(LOOKAHEAD_DEPTH + 1);

    logic [LOOKAHEAD_DEPTH-1:0] w_eq;

    always_comb begin
        for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
            w_eq[i] = (i_win[i] == i_ref[i]);
        end
    end

    // first mismatch below the cap wins
    always_comb begin
        o_len = i_lim;
        for (int i = LOOKAHEAD_DEPTH - 1; i >= 0; i--) begin
            if (!w_eq[i] && (LEN_W'(i) < i_lim)) begin
                o_len = LEN_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/lz77_greedy_encoder.sv @@
// Top level of the greedy LZ77 encoder: sequencer, lookahead, scan datapath.
`default_nettype none

// Greedy LZ77 encoder. Bytes enter one item at a time into a lookahead
// buffer; once it holds max_match bytes (or on an item flagged last_byte,
// which flushes it) the block emits tokens of (offset, length, literal,
// final). Each token decision streams the searched window oldest byte
// first, one byte per cycle from the history memory, followed by the
// lookahead bytes, through a row register; a single compare unit measures
// the match at each candidate distance and a running best is kept, so ties
// go to the most distant candidate. A token passes a check state, then,
// unless reach is zero, a scan state, where reach is the smaller of the
// window register and the bytes of history held; then an emit state that
// hands the token to the output register (waiting while that register
// still holds an unaccepted token) and a commit state that moves the
// covered bytes into history through the memory's single write port. An
// item that produces no token passes through the check state only; the
// input stays stalled until the item's last token sits in the output
// register, its bytes have moved into history and one more check has
// found no further token. The output register lets the next item in while
// that token waits. No clearing pass runs after reset: history is only read
// below its fill count. Configuration may be written whenever the block is
// idle.
module lz77_greedy_encoder #(
    parameter int HISTORY_DEPTH   = 1024,
    parameter int LOOKAHEAD_DEPTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // byte input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire lz77_pkg::t_in_item              i_in_item,
    // token output
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output lz77_pkg::t_out_item                  o_out_item,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lz77_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lz77_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import lz77_pkg::*;

    localparam int HA_W  = $clog2(HISTORY_DEPTH);
    localparam int HF_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int LA_W  = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int LI_W  = $clog2(LOOKAHEAD_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + LOOKAHEAD_DEPTH);
    localparam int CMP_W = HF_W + 11;
    localparam int MM_W  = LA_W + 5;

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    logic [10:0]     r_window;
    logic [4:0]      r_max_match;
    logic [LA_W-1:0] r_la_fill;
    logic [HF_W-1:0] r_hist_fill;
    logic [HA_W-1:0] r_head;
    logic            r_last;
    logic            r_out_valid;
    logic            r_src_v;
    logic            r_eval_v;

    // lookahead bytes, front at index 0
    logic [LOOKAHEAD_DEPTH-1:0][7:0] r_la;
    // copy of the lookahead, shifted out behind the history during a scan
    logic [LOOKAHEAD_DEPTH-1:0][7:0] r_feed;
    // row of streamed bytes; index 0 is the candidate's first byte
    logic [LOOKAHEAD_DEPTH-1:0][7:0] r_row;

    logic [7:0]      r_la_byte;
    logic            r_src_hist;
    logic [HA_W-1:0] r_rd_addr;
    logic [CNT_W-1:0] r_issue;
    logic [CNT_W-1:0] r_fed;
    logic [HF_W-1:0] r_reach;
    logic [HF_W-1:0] r_cand_d;
    logic [HF_W-1:0] r_best_d;
    logic [LA_W-1:0] r_best_len;
    logic [LA_W-1:0] r_lim;
    logic [LA_W-1:0] r_commit_left;
    t_out_item       r_out;

    // ---------------------------------------------------------------
    // token decision terms
    // ---------------------------------------------------------------
    logic [4:0]      w_mm1;
    logic [LA_W-1:0] w_m_eff;
    logic [LA_W-1:0] w_lim;
    logic [HF_W-1:0] w_reach;
    logic            w_need_token;
    logic [HF_W:0]   w_head_x;
    logic [HF_W:0]   w_reach_x;
    logic [HF_W:0]   w_start_x;

    // max_match of zero acts as one; above the buffer it saturates
    assign w_mm1 = (r_max_match == '0) ? 5'd1 : r_max_match;

    always_comb begin
        if (MM_W'(w_mm1) > MM_W'(LOOKAHEAD_DEPTH)) begin
            w_m_eff = LA_W'(LOOKAHEAD_DEPTH);
        end else begin
            w_m_eff = LA_W'(w_mm1);
        end
    end

    assign w_lim = (r_la_fill < w_m_eff) ? r_la_fill : w_m_eff;

    assign w_reach = (CMP_W'(r_window) < CMP_W'(r_hist_fill)) ? HF_W'(r_window)
                                                              : r_hist_fill;

    assign w_need_token = r_last ? (r_la_fill != '0) : (r_la_fill >= w_m_eff);

    // oldest searched byte sits reach slots behind the write head
    assign w_head_x  = (HF_W + 1)'(r_head);
    assign w_reach_x = (HF_W + 1)'(w_reach);
    always_comb begin
        if (w_head_x >= w_reach_x) begin
            w_start_x = w_head_x - w_reach_x;
        end else begin
            w_start_x = w_head_x + (HF_W + 1)'(HISTORY_DEPTH) - w_reach_x;
        end
    end

    // ---------------------------------------------------------------
    // scan datapath
    // ---------------------------------------------------------------
    logic            w_issue_hist;
    logic            w_issue_la;
    logic [7:0]      w_mem_rdata;
    logic [7:0]      w_byte_in;
    logic [LA_W-1:0] w_cand_len;
    logic            w_in_acc;
    logic            w_out_free;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_issue_hist = (r_state == S_SCAN) && (r_issue < CNT_W'(r_reach));
    assign w_issue_la   = (r_state == S_SCAN) && !w_issue_hist &&
                          (r_issue < CNT_W'(r_reach) + CNT_W'(LOOKAHEAD_DEPTH - 1));

    assign w_byte_in = r_src_hist ? w_mem_rdata : r_la_byte;

    lz77_hist_mem #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist_mem (
        .i_clk   (i_clk),
        .i_we    (r_state == S_COMMIT),
        .i_waddr (r_head),
        .i_wdata (r_la[0]),
        .i_raddr (r_rd_addr),
        .o_rdata (w_mem_rdata)
    );

    lz77_match_unit #(
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
    ) u_match_unit (
        .i_win (r_row),
        .i_ref (r_la),
        .i_lim (r_lim),
        .o_len (w_cand_len)
    );

    // ---------------------------------------------------------------
    // token assembly
    // ---------------------------------------------------------------
    logic              w_has_match;
    logic [LA_W-1:0]   w_tok_len;
    logic [HF_W+10:0]  w_off_wide;
    logic [LA_W+4:0]   w_len_wide;
    t_out_item         w_token;

    assign w_has_match = (r_best_len != '0);
    assign w_tok_len   = w_has_match ? r_best_len : LA_W'(1);
    assign w_off_wide  = (HF_W + 11)'(r_best_d);
    assign w_len_wide  = (LA_W + 5)'(w_tok_len);

    always_comb begin
        w_token.match_offset  = w_has_match ? w_off_wide[10:0] : 11'd0;
        w_token.match_length  = w_len_wide[4:0];
        w_token.literal_value = w_has_match ? 8'd0 : r_la[0];
        w_token.final_token   = r_last && (r_la_fill == w_tok_len);
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!w_need_token) begin
                    n_state = S_IDLE;
                end else if (w_reach == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // last candidate is distance one
                if (r_eval_v && (r_cand_d == HF_W'(1))) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (r_commit_left == LA_W'(1)) begin
                    n_state = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RST;
            r_max_match <= MAX_MATCH_RST;
            r_la_fill   <= '0;
            r_hist_fill <= '0;
            r_head      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_src_v     <= 1'b0;
            r_eval_v    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW:    r_window    <= i_cfg_data;
                    CFG_MAX_MATCH: r_max_match <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                r_last <= i_in_item.last_byte;
                if (r_la_fill < LA_W'(LOOKAHEAD_DEPTH)) begin
                    r_la_fill <= r_la_fill + LA_W'(1);
                end
            end

            // end of text: history is dropped
            if ((r_state == S_CHECK) && r_last && !w_need_token) begin
                r_hist_fill <= '0;
                r_head      <= '0;
            end

            if (r_state == S_COMMIT) begin
                r_la_fill <= r_la_fill - LA_W'(1);
                r_head    <= (r_head == HA_W'(HISTORY_DEPTH - 1)) ? '0
                                                                  : r_head + HA_W'(1);
                if (r_hist_fill != HF_W'(HISTORY_DEPTH)) begin
                    r_hist_fill <= r_hist_fill + HF_W'(1);
                end
            end

            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            r_src_v  <= w_issue_hist || w_issue_la;
            // a candidate is complete once a full row has been streamed
            r_eval_v <= r_src_v && (r_fed >= CNT_W'(LOOKAHEAD_DEPTH - 1));
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (r_la_fill < LA_W'(LOOKAHEAD_DEPTH))) begin
            r_la[r_la_fill[LI_W-1:0]] <= i_in_item.in_byte;
        end

        if ((r_state == S_CHECK) && w_need_token) begin
            r_issue    <= '0;
            r_fed      <= '0;
            r_rd_addr  <= w_start_x[HA_W-1:0];
            r_feed     <= r_la;
            r_best_len <= '0;
            r_best_d   <= '0;
            r_cand_d   <= w_reach;
            r_reach    <= w_reach;
            r_lim      <= w_lim;
        end

        r_src_hist <= w_issue_hist;

        if (w_issue_hist) begin
            r_rd_addr <= (r_rd_addr == HA_W'(HISTORY_DEPTH - 1)) ? '0
                                                                 : r_rd_addr + HA_W'(1);
            r_issue   <= r_issue + CNT_W'(1);
        end else if (w_issue_la) begin
            r_la_byte <= r_feed[0];
            for (int i = 0; i < LOOKAHEAD_DEPTH - 1; i++) begin
                r_feed[i] <= r_feed[i + 1];
            end
            r_issue <= r_issue + CNT_W'(1);
        end

        if (r_src_v) begin
            for (int i = 0; i < LOOKAHEAD_DEPTH - 1; i++) begin
                r_row[i] <= r_row[i + 1];
            end
            r_row[LOOKAHEAD_DEPTH-1] <= w_byte_in;
            r_fed <= r_fed + CNT_W'(1);
        end

        // strict compare keeps the most distant of equal matches
        if (r_eval_v) begin
            if (w_cand_len > r_best_len) begin
                r_best_len <= w_cand_len;
                r_best_d   <= r_cand_d;
            end
            r_cand_d <= r_cand_d - HF_W'(1);
        end

        if ((r_state == S_EMIT) && w_out_free) begin
            r_out         <= w_token;
            r_commit_left <= w_tok_len;
        end

        // covered bytes leave the lookahead front one per cycle
        if (r_state == S_COMMIT) begin
            for (int i = 0; i < LOOKAHEAD_DEPTH - 1; i++) begin
                r_la[i] <= r_la[i + 1];
            end
            r_commit_left <= r_commit_left - LA_W'(1);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_la_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_la_fill <= LA_W'(LOOKAHEAD_DEPTH))
        else $error("lookahead fill beyond buffer depth");

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_CHECK))
        else $error("accepted item did not start a token check");

    a_best_in_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_best_len <= r_lim))
        else $error("best match longer than the search limit");

    a_commit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && w_out_free) |-> (w_tok_len <= r_la_fill))
        else $error("token covers more bytes than the lookahead holds");

endmodule

`default_nettype wire
